// File: rtl/compass_heading_from_xy_core_defines.svh
// Assertion macros shared by the compass heading RTL.
`ifndef COMPASS_HEADING_FROM_XY_CORE_DEFINES_SVH
`define COMPASS_HEADING_FROM_XY_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define CHXY_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
// Next-cycle implication; the consequent may carry a further constant delay.
`define CHXY_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
      else $error("assertion failed: next-cycle implication");
`else
`define CHXY_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define CHXY_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: rtl/chxy_pkg.sv
package chxy_pkg;

   // Angle search: whole degrees 0..44 inside one octant, six bits.
   localparam int ANGLE_BITS = 6;
   localparam logic [ANGLE_BITS-1:0] OCTANT_LAST = 6'd44;
   localparam int TAB_DEPTH = 45;

   // In-quadrant angle for equal legs and the top of a quadrant.
   localparam logic [6:0] ANGLE_EQUAL    = 7'd45;
   localparam logic [6:0] ANGLE_QUAD_TOP = 7'd89;

   // Quadrant codes, measured clockwise from +x toward -y.
   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   localparam logic [8:0] BASE_Q0 = 9'd0;
   localparam logic [8:0] BASE_Q1 = 9'd90;
   localparam logic [8:0] BASE_Q2 = 9'd180;
   localparam logic [8:0] BASE_Q3 = 9'd270;
   localparam logic [8:0] HEADING_LIMIT = 9'd360;

   // Control that travels with each item down the pipe.
   typedef struct packed {
      logic       valid;
      logic [1:0] quad;
      logic       equal;
      logic       swap;
   } meta_type;

   // Q2.62 trig tables, built at elaboration by Taylor series.
   localparam logic [63:0] Q62_ONE = 64'h4000_0000_0000_0000;
   localparam logic [63:0] PI_Q62  = 64'hC90F_DAA2_2168_C235;
   localparam logic [63:0] DEG_Q62 = PI_Q62 / 64'd180;
   localparam int TAYLOR_TERMS = 12;

   typedef logic [63:0] trig_tab_type [0:TAB_DEPTH-1];

   function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = 128'(a) * 128'(b);
      return p[125:62];
   endfunction

   // Restoring long division, used only while the tables are built.
   function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic trig_tab_type build_tab(logic want_cos);
      trig_tab_type tab;
      logic [63:0] t;
      logic [63:0] t2;
      logic [63:0] s;
      logic [63:0] c;
      logic [63:0] ts;
      logic [63:0] tc;
      logic [63:0] ds;
      logic [63:0] dc;
      for (int k = 0; k < TAB_DEPTH; k++) begin
         t  = 64'(DEG_Q62 * 64'(k));
         t2 = qmul(t, t);
         s  = t;
         c  = Q62_ONE;
         ts = t;
         tc = Q62_ONE;
         for (int n = 1; n <= TAYLOR_TERMS; n++) begin
            ds = 64'((2 * n) * (2 * n + 1));
            dc = 64'((2 * n - 1) * (2 * n));
            ts = udiv64(qmul(ts, t2), ds);
            tc = udiv64(qmul(tc, t2), dc);
            if (n % 2 == 1) begin
               s = s - ts;
               c = c - tc;
            end else begin
               s = s + ts;
               c = c + tc;
            end
         end
         tab[k] = want_cos ? c : s;
      end
      return tab;
   endfunction

   localparam trig_tab_type SIN_TAB = build_tab(1'b0);
   localparam trig_tab_type COS_TAB = build_tab(1'b1);

endpackage

// File: rtl/chxy_prep.sv
`include "compass_heading_from_xy_core_defines.svh"

module chxy_prep #(
   parameter int AXIS_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [AXIS_WIDTH-1:0] field_x,
   input  logic [AXIS_WIDTH-1:0] field_y,
   output chxy_pkg::meta_type    meta_o,
   output logic [AXIS_WIDTH-1:0] u_o,
   output logic [AXIS_WIDTH-1:0] v_o
);

   logic                  x_neg;
   logic                  y_neg;
   logic [AXIS_WIDTH-1:0] ax;
   logic [AXIS_WIDTH-1:0] ay;
   logic                  x_pos;
   logic                  ey_pos;
   logic                  ey_neg;
   logic [AXIS_WIDTH-1:0] leg_a;
   logic [AXIS_WIDTH-1:0] leg_b;
   logic [1:0]            quad;
   chxy_pkg::meta_type    meta_in;
   chxy_pkg::meta_type    meta_ff;
   logic [AXIS_WIDTH-1:0] u_in;
   logic [AXIS_WIDTH-1:0] v_in;
   logic [AXIS_WIDTH-1:0] u_ff;
   logic [AXIS_WIDTH-1:0] v_ff;

   // Split each axis into sign and magnitude; the most negative value wraps to 2^(W-1).
   always_comb begin
      x_neg  = field_x[AXIS_WIDTH-1];
      y_neg  = field_y[AXIS_WIDTH-1];
      ax     = x_neg ? AXIS_WIDTH'(-field_x) : field_x;
      ay     = y_neg ? AXIS_WIDTH'(-field_y) : field_y;
      x_pos  = !x_neg && (ax != '0);
      ey_pos = y_neg && (ay != '0);
      ey_neg = !y_neg && (ay != '0);
   end

   // Pick the quadrant and its two legs; the angle grows toward -y.
   always_comb begin
      priority if ((ax == '0) && (ay == '0)) begin
         quad  = chxy_pkg::QUAD_0;
         leg_a = '0;
         leg_b = AXIS_WIDTH'(1);
      end else if (x_pos && !ey_neg) begin
         quad  = chxy_pkg::QUAD_0;
         leg_a = ay;
         leg_b = ax;
      end else if (!x_pos && ey_pos) begin
         quad  = chxy_pkg::QUAD_1;
         leg_a = ax;
         leg_b = ay;
      end else if (x_neg && !ey_pos) begin
         quad  = chxy_pkg::QUAD_2;
         leg_a = ay;
         leg_b = ax;
      end else begin
         quad  = chxy_pkg::QUAD_3;
         leg_a = ax;
         leg_b = ay;
      end
   end

   // Order the legs so the octant search always sees u <= v.
   always_comb begin
      meta_in.valid = accept;
      meta_in.quad  = quad;
      meta_in.equal = (leg_a == leg_b);
      meta_in.swap  = (leg_a > leg_b);
      u_in          = meta_in.swap ? leg_b : leg_a;
      v_in          = meta_in.swap ? leg_a : leg_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         meta_ff <= '0;
      end else begin
         meta_ff <= meta_in;
      end
   end

   always_ff @(posedge clock) begin
      u_ff <= u_in;
      v_ff <= v_in;
   end

   assign meta_o = meta_ff;
   assign u_o    = u_ff;
   assign v_o    = v_ff;

   `CHXY_ASSERT_IMPLIES(a_prep_order, clock, reset, meta_ff.valid, u_ff <= v_ff)

endmodule

// File: rtl/chxy_cell.sv
`include "compass_heading_from_xy_core_defines.svh"

module chxy_cell #(
   parameter int MAG_W    = 16,
   parameter int STEP_BIT = 5
) (
   input  logic                              clock,
   input  logic                              reset,
   input  chxy_pkg::meta_type                meta_i,
   input  logic [MAG_W-1:0]                  u_i,
   input  logic [MAG_W-1:0]                  v_i,
   input  logic [chxy_pkg::ANGLE_BITS-1:0]   k_i,
   output chxy_pkg::meta_type                meta_o,
   output logic [MAG_W-1:0]                  u_o,
   output logic [MAG_W-1:0]                  v_o,
   output logic [chxy_pkg::ANGLE_BITS-1:0]   k_o
);

   localparam int KW     = chxy_pkg::ANGLE_BITS;
   localparam int PROD_W = MAG_W + 32;
   localparam int SUM_W  = PROD_W + 32;
   localparam logic [KW-1:0] STEP_MASK = KW'(1) << STEP_BIT;
   localparam logic [KW-1:0] LOW_MASK  = STEP_MASK - KW'(1);

   // Stage A: trial angle and its table entries.
   logic [KW-1:0]      cand_in;
   logic               ok_in;
   logic [KW-1:0]      idx;
   chxy_pkg::meta_type meta_a_ff;
   logic [MAG_W-1:0]   u_a_ff;
   logic [MAG_W-1:0]   v_a_ff;
   logic [KW-1:0]      k_a_ff;
   logic [KW-1:0]      cand_a_ff;
   logic               ok_a_ff;
   logic [63:0]        cos_a_ff;
   logic [63:0]        sin_a_ff;

   // Stage B: partial products.
   logic [PROD_W-1:0]  uch_in;
   logic [PROD_W-1:0]  ucl_in;
   logic [PROD_W-1:0]  vsh_in;
   logic [PROD_W-1:0]  vsl_in;
   chxy_pkg::meta_type meta_b_ff;
   logic [MAG_W-1:0]   u_b_ff;
   logic [MAG_W-1:0]   v_b_ff;
   logic [KW-1:0]      k_b_ff;
   logic [KW-1:0]      cand_b_ff;
   logic               ok_b_ff;
   logic [PROD_W-1:0]  uch_ff;
   logic [PROD_W-1:0]  ucl_ff;
   logic [PROD_W-1:0]  vsh_ff;
   logic [PROD_W-1:0]  vsl_ff;

   // Stage C: compare and decide the step bit.
   logic [SUM_W-1:0]   lhs;
   logic [SUM_W-1:0]   rhs;
   logic [KW-1:0]      k_c_in;
   chxy_pkg::meta_type meta_c_ff;
   logic [MAG_W-1:0]   u_c_ff;
   logic [MAG_W-1:0]   v_c_ff;
   logic [KW-1:0]      k_c_ff;

   // Set this cell's bit and look up sin and cos of the trial angle.
   always_comb begin
      cand_in = k_i | STEP_MASK;
      ok_in   = (cand_in <= chxy_pkg::OCTANT_LAST);
      idx     = ok_in ? cand_in : '0;
   end

   // Split each 64-bit constant in halves to keep the multipliers narrow.
   always_comb begin
      uch_in = PROD_W'(u_a_ff) * PROD_W'(cos_a_ff[63:32]);
      ucl_in = PROD_W'(u_a_ff) * PROD_W'(cos_a_ff[31:0]);
      vsh_in = PROD_W'(v_a_ff) * PROD_W'(sin_a_ff[63:32]);
      vsl_in = PROD_W'(v_a_ff) * PROD_W'(sin_a_ff[31:0]);
   end

   // Keep the trial angle where u*cos >= v*sin.
   always_comb begin
      lhs    = {uch_ff, 32'd0} + {32'd0, ucl_ff};
      rhs    = {vsh_ff, 32'd0} + {32'd0, vsl_ff};
      k_c_in = (ok_b_ff && (lhs >= rhs)) ? cand_b_ff : k_b_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         meta_a_ff <= '0;
         meta_b_ff <= '0;
         meta_c_ff <= '0;
      end else begin
         meta_a_ff <= meta_i;
         meta_b_ff <= meta_a_ff;
         meta_c_ff <= meta_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      u_a_ff    <= u_i;
      v_a_ff    <= v_i;
      k_a_ff    <= k_i;
      cand_a_ff <= cand_in;
      ok_a_ff   <= ok_in;
      cos_a_ff  <= chxy_pkg::COS_TAB[idx];
      sin_a_ff  <= chxy_pkg::SIN_TAB[idx];

      u_b_ff    <= u_a_ff;
      v_b_ff    <= v_a_ff;
      k_b_ff    <= k_a_ff;
      cand_b_ff <= cand_a_ff;
      ok_b_ff   <= ok_a_ff;
      uch_ff    <= uch_in;
      ucl_ff    <= ucl_in;
      vsh_ff    <= vsh_in;
      vsl_ff    <= vsl_in;

      u_c_ff    <= u_b_ff;
      v_c_ff    <= v_b_ff;
      k_c_ff    <= k_c_in;
   end

   assign meta_o = meta_c_ff;
   assign u_o    = u_c_ff;
   assign v_o    = v_c_ff;
   assign k_o    = k_c_ff;

   `CHXY_ASSERT_IMPLIES(a_cell_range, clock, reset, meta_c_ff.valid, k_c_ff <= chxy_pkg::OCTANT_LAST)
   `CHXY_ASSERT_IMPLIES(a_cell_low_clear, clock, reset, meta_c_ff.valid, (k_c_ff & LOW_MASK) == '0)

endmodule

// File: rtl/compass_heading_from_xy_core.sv
// Compass heading core: takes one signed field pair (x, y) per clock and returns
// the heading -atan2(y, x) in whole degrees 0..359, truncated toward zero. The
// core is fully pipelined: an item is accepted in every cycle that start is high
// outside reset (busy is high only during reset), and its heading appears on
// rsp_heading_degrees with rsp_strobe, in order. The receiver cannot stall the
// core, so each result must be taken in the one cycle its strobe is high. The
// pipeline is one input stage, six search cells of three stages each (table
// lookup, four partial products of the legs with 32-bit table halves, wide
// compare), one per bit of the in-octant angle, and one output stage.
`include "compass_heading_from_xy_core_defines.svh"

module compass_heading_from_xy_core #(
   parameter int AXIS_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [AXIS_WIDTH-1:0] req_field_x,
   input  logic [AXIS_WIDTH-1:0] req_field_y,
   output logic                  rsp_strobe,
   output logic [8:0]            rsp_heading_degrees
);

   localparam int KW     = chxy_pkg::ANGLE_BITS;
   localparam int LAT    = 2 + 3 * KW;
   localparam int LAT_M1 = LAT - 1;

   chxy_pkg::meta_type    link_meta [0:KW];
   logic [AXIS_WIDTH-1:0] link_u    [0:KW];
   logic [AXIS_WIDTH-1:0] link_v    [0:KW];
   logic [KW-1:0]         link_k    [0:KW];

   logic                  accept;
   logic [6:0]            angle;
   logic [8:0]            base;
   logic [8:0]            heading_in;
   logic [8:0]            heading_ff;
   logic                  strobe_ff;

   assign busy   = reset;
   assign accept = start && !busy;

   // Place the item in a quadrant and order its legs.
   chxy_prep #(
      .AXIS_WIDTH(AXIS_WIDTH)
   ) u_prep (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .field_x(req_field_x),
      .field_y(req_field_y),
      .meta_o (link_meta[0]),
      .u_o    (link_u[0]),
      .v_o    (link_v[0])
   );

   assign link_k[0] = '0;

   // Resolve the in-octant angle one bit per cell, most significant first.
   for (genvar i = 0; i < KW; i++) begin : g_cell
      chxy_cell #(
         .MAG_W   (AXIS_WIDTH),
         .STEP_BIT(KW - 1 - i)
      ) u_cell (
         .clock (clock),
         .reset (reset),
         .meta_i(link_meta[i]),
         .u_i   (link_u[i]),
         .v_i   (link_v[i]),
         .k_i   (link_k[i]),
         .meta_o(link_meta[i+1]),
         .u_o   (link_u[i+1]),
         .v_o   (link_v[i+1]),
         .k_o   (link_k[i+1])
      );
   end

   // Unfold the octant angle into the quadrant and add the quadrant base.
   always_comb begin
      priority if (link_meta[KW].equal) begin
         angle = chxy_pkg::ANGLE_EQUAL;
      end else if (link_meta[KW].swap) begin
         angle = chxy_pkg::ANGLE_QUAD_TOP - 7'(link_k[KW]);
      end else begin
         angle = 7'(link_k[KW]);
      end
      unique case (link_meta[KW].quad)
         chxy_pkg::QUAD_0: base = chxy_pkg::BASE_Q0;
         chxy_pkg::QUAD_1: base = chxy_pkg::BASE_Q1;
         chxy_pkg::QUAD_2: base = chxy_pkg::BASE_Q2;
         chxy_pkg::QUAD_3: base = chxy_pkg::BASE_Q3;
         default:          base = chxy_pkg::BASE_Q0;
      endcase
      heading_in = base + {2'b00, angle};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= link_meta[KW].valid;
      end
   end

   always_ff @(posedge clock) begin
      heading_ff <= heading_in;
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_heading_degrees = heading_ff;

   `CHXY_ASSERT_NEXT(a_top_latency, clock, reset, accept, ##LAT_M1 rsp_strobe)
   `CHXY_ASSERT_IMPLIES(a_top_range, clock, reset, rsp_strobe, rsp_heading_degrees < chxy_pkg::HEADING_LIMIT)

endmodule
